@@ hw/rtl/tccp_pkg.sv @@
// ----------------------------------------------------------------------------
// tccp_pkg
// Shared types and constants of the text console cursor placer.
// ----------------------------------------------------------------------------
package tccp_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ROWS    = 2'd1;

  localparam logic [7:0] COLUMNS_RESET = 8'd40;
  localparam logic [7:0] ROWS_RESET    = 8'd15;

  localparam logic [7:0] LEAD_THRESHOLD = 8'hA0;
  localparam logic [7:0] LINE_FEED      = 8'h0A;

  localparam logic [1:0] CMD_SINGLE = 2'd0;
  localparam logic [1:0] CMD_DOUBLE = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  // Results of one byte: optional scroll, optional draw, optional scroll.
  typedef struct packed {
    logic       pre_scroll;
    logic       draw;
    logic       post_scroll;
    logic [1:0] command;
    logic [7:0] glyph_column;
    logic [7:0] glyph_row;
    logic [7:0] first_code;
    logic [7:0] second_code;
  } plan_t;

endpackage

@@ hw/rtl/tccp_planner.sv @@
// ----------------------------------------------------------------------------
// tccp_planner
// Input register, cursor state and the per-byte placement logic.
// ----------------------------------------------------------------------------
module tccp_planner (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    byte_value_i,
  input  logic          end_of_packet_i,
  input  logic [7:0]    columns_i,
  input  logic [7:0]    rows_i,
  input  logic          plan_ready_i,
  output logic          plan_valid_o,
  output tccp_pkg::plan_t plan_o
);
  import tccp_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eop_q;
  logic       take;

  logic [7:0] col_q, col_d;
  logic [7:0] row_q, row_d;
  logic       lead_q, lead_d;
  logic [7:0] held_q, held_d;

  logic [8:0] cols9, rows9, cells9;
  logic [8:0] row_inc9, row_a_inc9, col_b9;
  logic       wrap1, scroll1, wrap2, scroll2;
  logic [7:0] col_a, row_a, col_b;
  logic       is_double;

  assign take         = in_valid_q && plan_ready_i;
  assign in_ready_o   = !in_valid_q || plan_ready_i;
  assign plan_valid_o = in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= byte_value_i;
      eop_q  <= end_of_packet_i;
    end
  end

  // placement arithmetic
  always_comb begin
    is_double  = lead_q;
    cols9      = {1'b0, columns_i};
    rows9      = {1'b0, rows_i};
    cells9     = is_double ? 9'd2 : 9'd1;
    row_inc9   = {1'b0, row_q} + 9'd1;
    wrap1      = ({1'b0, col_q} + cells9) > cols9;
    scroll1    = wrap1 && (row_inc9 >= rows9);
    col_a      = wrap1 ? 8'd0 : col_q;
    row_a      = (wrap1 && !scroll1) ? row_inc9[7:0] : row_q;
    col_b9     = {1'b0, col_a} + cells9;
    col_b      = col_b9[7:0];
    wrap2      = {1'b0, col_b} >= cols9;
    row_a_inc9 = {1'b0, row_a} + 9'd1;
    scroll2    = wrap2 && (row_a_inc9 >= rows9);
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    lead_d = lead_q;
    held_d = held_q;
    plan_o = '0;
    if (lead_q) begin
      lead_d              = 1'b0;
      plan_o.pre_scroll   = scroll1;
      plan_o.draw         = 1'b1;
      plan_o.post_scroll  = scroll2;
      plan_o.command      = CMD_DOUBLE;
      plan_o.glyph_column = col_a;
      plan_o.glyph_row    = row_a;
      plan_o.first_code   = held_q;
      plan_o.second_code  = byte_q;
      col_d               = wrap2 ? 8'd0 : col_b;
      row_d               = (wrap2 && !scroll2) ? row_a_inc9[7:0] : row_a;
    end else if (byte_q >= LEAD_THRESHOLD && !eop_q) begin
      lead_d = 1'b1;
      held_d = byte_q;
    end else if (byte_q == LINE_FEED) begin
      plan_o.pre_scroll = row_inc9 >= rows9;
      col_d             = 8'd0;
      row_d             = (row_inc9 >= rows9) ? row_q : row_inc9[7:0];
    end else begin
      plan_o.pre_scroll   = scroll1;
      plan_o.draw         = 1'b1;
      plan_o.post_scroll  = scroll2;
      plan_o.command      = CMD_SINGLE;
      plan_o.glyph_column = col_a;
      plan_o.glyph_row    = row_a;
      plan_o.first_code   = byte_q;
      col_d               = wrap2 ? 8'd0 : col_b;
      row_d               = (wrap2 && !scroll2) ? row_a_inc9[7:0] : row_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 8'd0;
      row_q  <= 8'd0;
      lead_q <= 1'b0;
      held_q <= 8'd0;
    end else if (take) begin
      col_q  <= col_d;
      row_q  <= row_d;
      lead_q <= lead_d;
      held_q <= held_d;
    end
  end

endmodule

@@ hw/rtl/tccp_emitter.sv @@
// ----------------------------------------------------------------------------
// tccp_emitter
// Result register: holds one byte's plan and hands out its results in order.
// ----------------------------------------------------------------------------
module tccp_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            plan_valid_i,
  output logic            plan_ready_o,
  input  tccp_pkg::plan_t plan_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      command_o,
  output logic [7:0]      glyph_column_o,
  output logic [7:0]      glyph_row_o,
  output logic [7:0]      first_code_o,
  output logic [7:0]      second_code_o,
  output logic            last_result_o
);
  import tccp_pkg::*;

  logic [2:0] pend_q, pend_d, pend_rest;
  plan_t      plan_q;
  logic       fire, load;

  // bit 0: leading scroll, bit 1: draw, bit 2: trailing scroll
  assign pend_rest     = pend_q & (pend_q - 3'd1);
  assign out_valid_o   = |pend_q;
  assign fire          = out_valid_o && out_ready_i;
  assign last_result_o = pend_rest == 3'd0;
  assign plan_ready_o  = !out_valid_o || (fire && last_result_o);
  assign load          = plan_valid_i && plan_ready_o;

  always_comb begin
    pend_d = pend_q;
    if (load) begin
      pend_d = {plan_i.post_scroll, plan_i.draw, plan_i.pre_scroll};
    end else if (fire) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plan_q <= plan_i;
    end
  end

  always_comb begin
    if (pend_q[0] || !pend_q[1]) begin
      command_o      = CMD_SCROLL;
      glyph_column_o = 8'd0;
      glyph_row_o    = 8'd0;
      first_code_o   = 8'd0;
      second_code_o  = 8'd0;
    end else begin
      command_o      = plan_q.command;
      glyph_column_o = plan_q.glyph_column;
      glyph_row_o    = plan_q.glyph_row;
      first_code_o   = plan_q.first_code;
      second_code_o  = plan_q.second_code;
    end
  end

endmodule

@@ hw/rtl/text_console_cursor_placer_top.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_placer_top
// Places received text bytes on a character grid and issues draw and
// scroll requests.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------
//  in       | in        | in_valid / in_ready   | byte_value, end_of_packet
//  out      | out       | out_valid / out_ready | command, glyph_column/row,
//           |           |                       | first/second_code, last_result
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  A byte is held in the input register, then its 0 to 3 results leave the
//  result register one per cycle while out_ready is high; the result count
//  sets the rate. Reset clears cursor, held lead byte and pipeline;
//  registers return to 40 columns and 15 rows. cfg_ready is always high.
//  A stalled out channel holds the result and backs up into in_ready.
// ----------------------------------------------------------------------------
module text_console_cursor_placer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   byte_value_i,
  input  logic                         end_of_packet_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   command_o,
  output logic [7:0]                   glyph_column_o,
  output logic [7:0]                   glyph_row_o,
  output logic [7:0]                   first_code_o,
  output logic [7:0]                   second_code_o,
  output logic                         last_result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tccp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import tccp_pkg::*;

  logic [7:0] columns_q;
  logic [7:0] rows_q;
  logic       plan_valid, plan_ready;
  plan_t      plan;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COLUMNS: columns_q <= cfg_data_i;
        REG_ROWS:    rows_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tccp_planner u_planner (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_value_i    (byte_value_i),
    .end_of_packet_i (end_of_packet_i),
    .columns_i       (columns_q),
    .rows_i          (rows_q),
    .plan_ready_i    (plan_ready),
    .plan_valid_o    (plan_valid),
    .plan_o          (plan)
  );

  tccp_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .plan_valid_i   (plan_valid),
    .plan_ready_o   (plan_ready),
    .plan_i         (plan),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .glyph_column_o (glyph_column_o),
    .glyph_row_o    (glyph_row_o),
    .first_code_o   (first_code_o),
    .second_code_o  (second_code_o),
    .last_result_o  (last_result_o)
  );

endmodule

@@ hw/rtl/tccp_checker.sv @@
// ----------------------------------------------------------------------------
// tccp_checker
// Port-level checks of the cursor placer, bound to the top level.
// ----------------------------------------------------------------------------
module tccp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] command_o,
  input logic [7:0] glyph_column_o,
  input logic [7:0] glyph_row_o,
  input logic [7:0] first_code_o,
  input logic [7:0] second_code_o,
  input logic       last_result_o
);
  import tccp_pkg::*;

  a_scroll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_SCROLL |->
      glyph_column_o == 8'd0 && glyph_row_o == 8'd0 &&
      first_code_o == 8'd0 && second_code_o == 8'd0)
    else $error("scroll request with nonzero fields");

  a_single_trail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_SINGLE |-> second_code_o == 8'd0)
    else $error("single glyph with trail code");

  a_draw_then_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && command_o != CMD_SCROLL && !last_result_o |=>
      out_valid_o && command_o == CMD_SCROLL && last_result_o)
    else $error("draw not followed by wrap scroll");

  a_scroll_then_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && command_o == CMD_SCROLL && !last_result_o |=>
      out_valid_o && command_o != CMD_SCROLL)
    else $error("leading scroll not followed by draw");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(command_o) && $stable(first_code_o) &&
      $stable(last_result_o))
    else $error("stalled request changed");

endmodule

bind text_console_cursor_placer_top tccp_checker u_tccp_checker (.*);

@@ sim/text_console_cursor_placer_top_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_placer_top_tb
// Self-checking bench for the text console cursor placer. A directed table
// walks reset values, wrap, scroll and odd grid sizes, then random text
// (ASCII, GB2312 pairs, line feeds, noise) runs under several grid settings
// with random idling on both sides, except under one setting. Every request
// is checked against the behavioral cursor model or a typed expected request.
// ----------------------------------------------------------------------------
module text_console_cursor_placer_top_tb;
  import tccp_pkg::*;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int NUM_PHASES       = 6;
  localparam int ITEMS_PER_PHASE  = 30;

  // register indexes outside the map, writes must be dropped
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] first_code;
    logic [7:0] second_code;
    logic       last_result;
  } glyph_req_t;

  typedef struct {
    logic               is_reg;
    logic [CfgIdxW-1:0] reg_idx;
    logic [7:0]         value;
    logic               eop;
    int                 typed_count;
    glyph_req_t         typed_req;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         byte_value_i = '0;
  logic               end_of_packet_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         command_o;
  logic [7:0]         glyph_column_o;
  logic [7:0]         glyph_row_o;
  logic [7:0]         first_code_o;
  logic [7:0]         second_code_o;
  logic               last_result_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  text_console_cursor_placer_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_value_i    (byte_value_i),
    .end_of_packet_i (end_of_packet_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .command_o       (command_o),
    .glyph_column_o  (glyph_column_o),
    .glyph_row_o     (glyph_row_o),
    .first_code_o    (first_code_o),
    .second_code_o   (second_code_o),
    .last_result_o   (last_result_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // cursor model state
  logic [7:0] grid_cols = COLUMNS_RESET;
  logic [7:0] grid_rows = ROWS_RESET;
  logic [7:0] cur_col   = '0;
  logic [7:0] cur_row   = '0;
  logic       lead_held = 1'b0;
  logic [7:0] lead_byte = '0;

  glyph_req_t step_reqs[$];
  glyph_req_t expected_reqs[$];
  plan_row_t  plan[$];

  int  idle_max = 4;
  bit  hold_long = 1'b0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  reqs_checked = 0;
  int  doubles_seen = 0;
  int  scrolls_seen = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;

  function automatic glyph_req_t make_req(logic [1:0] cmd, logic [7:0] col, logic [7:0] row,
                                          logic [7:0] c1, logic [7:0] c2, logic last = 1'b0);
    glyph_req_t r;
    r.command     = cmd;
    r.column      = col;
    r.row         = row;
    r.first_code  = c1;
    r.second_code = c2;
    r.last_result = last;
    return r;
  endfunction

  function automatic void line_step();
    cur_col = '0;
    if (int'(cur_row) + 1 >= int'(grid_rows)) begin
      step_reqs.push_back(make_req(CMD_SCROLL, '0, '0, '0, '0));
    end else begin
      cur_row = cur_row + 8'd1;
    end
  endfunction

  function automatic void place_glyph(logic [1:0] cmd, int cells, logic [7:0] c1,
                                      logic [7:0] c2);
    if (int'(cur_col) + cells > int'(grid_cols)) line_step();
    step_reqs.push_back(make_req(cmd, cur_col, cur_row, c1, c2));
    cur_col = 8'(int'(cur_col) + cells);
    if (cur_col >= grid_cols) line_step();
  endfunction

  function automatic void place_byte(logic [7:0] b, logic eop);
    glyph_req_t tail;
    step_reqs.delete();
    if (lead_held) begin
      lead_held = 1'b0;
      place_glyph(CMD_DOUBLE, 2, lead_byte, b);
    end else if (b >= LEAD_THRESHOLD && !eop) begin
      lead_held = 1'b1;
      lead_byte = b;
    end else if (b == LINE_FEED) begin
      line_step();
    end else begin
      place_glyph(CMD_SINGLE, 1, b, 8'd0);
    end
    if (step_reqs.size() > 0) begin
      tail = step_reqs.pop_back();
      tail.last_result = 1'b1;
      step_reqs.push_back(tail);
    end
  endfunction

  function automatic plan_row_t byte_row(logic [7:0] b, logic eop, int n = -1,
                                         glyph_req_t req = '0);
    plan_row_t r;
    r.is_reg      = 1'b0;
    r.reg_idx     = '0;
    r.value       = b;
    r.eop         = eop;
    r.typed_count = n;
    r.typed_req   = req;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    plan_row_t r;
    r = byte_row(val, 1'b0);
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic eop, int typed_count = -1,
                           glyph_req_t typed_req = '0);
    int gap;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    byte_value_i    <= b;
    end_of_packet_i <= eop;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    place_byte(b, eop);
    if (typed_count < 0) begin
      foreach (step_reqs[i]) expected_reqs.push_back(step_reqs[i]);
    end else if (typed_count > 0) begin
      expected_reqs.push_back(typed_req);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_reqs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
    if (idx == REG_COLUMNS) grid_cols = val;
    else if (idx == REG_ROWS) grid_rows = val;
  endtask

  task automatic send_text(int count);
    int sent;
    int kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        send_byte(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(0, 7) == 0);
        sent++;
      end else if (kind <= 6) begin
        send_byte(8'($urandom_range(8'hA1, 8'hF7)), 1'b0);
        send_byte(8'($urandom_range(8'hA1, 8'hFE)), $urandom_range(0, 3) == 0);
        sent += 2;
      end else if (kind == 7) begin
        send_byte(LINE_FEED, 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        sent++;
      end
    end
  endtask

  // request checker
  always @(posedge clk_i) begin
    glyph_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reqs.size() == 0) begin
        $error("unexpected request: command %0d column %0d row %0d", command_o,
               glyph_column_o, glyph_row_o);
        mismatches++;
      end else begin
        want = expected_reqs.pop_front();
        check_field("command", want.command, command_o);
        check_field("glyph_column", want.column, glyph_column_o);
        check_field("glyph_row", want.row, glyph_row_o);
        check_field("first_code", want.first_code, first_code_o);
        check_field("second_code", want.second_code, second_code_o);
        check_field("last_result", want.last_result, last_result_o);
        reqs_checked++;
        if (command_o == CMD_DOUBLE) doubles_seen++;
        if (command_o == CMD_SCROLL) scrolls_seen++;
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = $urandom_range(0, idle_max);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests pending", cycle_count,
               expected_reqs.size());
      $display("[text_console_cursor_placer_top] ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0] cols;
    logic [7:0] rows;

    // after reset: 40 x 15 grid, cursor at the origin
    plan.push_back(byte_row(8'h41, 1'b0, 1, make_req(CMD_SINGLE, 0, 0, 8'h41, 0, 1)));
    plan.push_back(byte_row(8'h00, 1'b1, 1, make_req(CMD_SINGLE, 1, 0, 8'h00, 0, 1)));
    // high byte at end of packet is drawn single
    plan.push_back(byte_row(8'hFF, 1'b1, 1, make_req(CMD_SINGLE, 2, 0, 8'hFF, 0, 1)));
    plan.push_back(byte_row(8'hA0, 1'b0, 0));
    plan.push_back(byte_row(8'hA1, 1'b0, 1, make_req(CMD_DOUBLE, 3, 0, 8'hA0, 8'hA1, 1)));
    plan.push_back(byte_row(8'h9F, 1'b0, 1, make_req(CMD_SINGLE, 5, 0, 8'h9F, 0, 1)));
    plan.push_back(byte_row(LINE_FEED, 1'b0, 0));
    // line feed and end-of-packet bytes still count as trail bytes
    plan.push_back(byte_row(8'hFF, 1'b0, 0));
    plan.push_back(byte_row(LINE_FEED, 1'b1, 1,
                            make_req(CMD_DOUBLE, 0, 1, 8'hFF, LINE_FEED, 1)));
    plan.push_back(byte_row(8'hB0, 1'b0, 0));
    plan.push_back(byte_row(8'hA0, 1'b1, 1, make_req(CMD_DOUBLE, 2, 1, 8'hB0, 8'hA0, 1)));
    // cursor beyond the new column count
    plan.push_back(reg_row(REG_COLUMNS, 8'd3));
    plan.push_back(byte_row(8'h42, 1'b0));
    // bottom row: wrap after draw scrolls
    plan.push_back(reg_row(REG_ROWS, 8'd3));
    plan.push_back(byte_row(8'hC0, 1'b0, 0));
    plan.push_back(byte_row(8'hC1, 1'b0));
    plan.push_back(byte_row(LINE_FEED, 1'b0, 1, make_req(CMD_SCROLL, 0, 0, 0, 0, 1)));
    // single column: double glyph wraps before and after
    plan.push_back(reg_row(REG_COLUMNS, 8'd1));
    plan.push_back(byte_row(8'h43, 1'b0));
    plan.push_back(byte_row(8'hD0, 1'b0, 0));
    plan.push_back(byte_row(8'hD1, 1'b0));
    // zero-sized grid, row beyond the row count
    plan.push_back(reg_row(REG_COLUMNS, 8'd0));
    plan.push_back(reg_row(REG_ROWS, 8'd0));
    plan.push_back(byte_row(8'h44, 1'b1));
    plan.push_back(byte_row(LINE_FEED, 1'b1, 1, make_req(CMD_SCROLL, 0, 0, 0, 0, 1)));
    // unmapped indexes are dropped
    plan.push_back(reg_row(REG_SPARE_A, 8'd7));
    plan.push_back(reg_row(REG_SPARE_B, 8'd255));
    plan.push_back(reg_row(REG_COLUMNS, 8'd255));
    plan.push_back(reg_row(REG_ROWS, 8'd255));
    plan.push_back(byte_row(8'h45, 1'b0));
    plan.push_back(byte_row(LINE_FEED, 1'b0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        send_byte(plan[i].value, plan[i].eop, plan[i].typed_count, plan[i].typed_req);
      end
    end
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          cols = 8'd2;
          rows = 8'd1;
        end
        1: begin
          cols = 8'd255;
          rows = 8'd255;
        end
        2: begin
          cols = COLUMNS_RESET;
          rows = ROWS_RESET;
        end
        3: begin
          cols = 8'($urandom_range(2, 12));
          rows = 8'($urandom_range(1, 6));
        end
        4: begin
          cols = 8'($urandom_range(2, 255));
          rows = 8'($urandom_range(1, 255));
        end
        default: begin
          cols = 8'd3;
          rows = 8'd2;
        end
      endcase
      write_reg(REG_COLUMNS, cols);
      write_reg(REG_ROWS, rows);
      idle_max  = (p == 2) ? 0 : 4;
      hold_long = (p == 0);
      send_text(ITEMS_PER_PHASE);
      settle();
    end

    $display("Placed %0d bytes across %0d register writes, %0d requests checked",
             bytes_sent, reg_writes, reqs_checked);
    $display("Requests included %0d double-width glyphs and %0d scrolls",
             doubles_seen, scrolls_seen);
    if (mismatches == 0 && expected_reqs.size() == 0) begin
      $display("[text_console_cursor_placer_top] OK");
    end else begin
      $display("[text_console_cursor_placer_top] ERROR");
    end
    $finish;
  end

endmodule
